// ===== hdl/euu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euu_pkg
// Shared types and constants for the escape-to-UTF-16 decoder.
// ----------------------------------------------------------------------------
package euu_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONASCII = 2'd1,
    ST_BADHEX   = 2'd2,
    ST_TOOBIG   = 2'd3
  } status_e;

  localparam logic [31:0] MaxPoint   = 32'h0010_FFFF;
  localparam logic [20:0] PlaneBase  = 21'h1_0000;
  localparam logic [7:0]  ChBackslash = 8'h5C;
  localparam logic [7:0]  ChLowerU   = 8'h75;
  localparam logic [7:0]  ChUpperU   = 8'h55;
  localparam logic [3:0]  HexTen     = 4'hA;
  localparam logic [3:0]  ShortDigits = 4'd4;
  localparam logic [3:0]  LongDigits = 4'd8;
  localparam logic [5:0]  LeadPrefix = 6'b110110;
  localparam logic [5:0]  TrailPrefix = 6'b110111;

  // One queued command from the parser to the emitter
  typedef struct packed {
    logic        is_pair; // data holds point minus 0x10000, emit two units
    logic [19:0] data;    // code unit in [15:0] when not a pair
    status_e     status;
    logic        last;
  } cmd_t;

endpackage

// ===== hdl/euu_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euu_stream_if
// Valid/ready channels for input bytes, output code units and configuration.
// ----------------------------------------------------------------------------
interface euu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface euu_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output code_unit, output status, output last, input ready);
  modport sink   (input valid, input code_unit, input status, input last, output ready);
endinterface

interface euu_cfg_if;
  logic valid;
  logic ready;
  logic escape_enable;

  modport source (output valid, output escape_enable, input ready);
  modport sink   (input valid, input escape_enable, output ready);
endinterface

// ===== hdl/euu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euu_front
// Byte parser: tracks escape state, assembles code points, queues commands.
// ----------------------------------------------------------------------------
module euu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  euu_byte_if.sink      in_if,
  euu_cfg_if.sink       cfg_if,
  input  logic          q_full_i,
  output logic          push_o,
  output euu_pkg::cmd_t cmd_o
);
  import euu_pkg::*;

  typedef enum logic [3:0] {
    MODE_PLAIN  = 4'b0001,
    MODE_BSLASH = 4'b0010,
    MODE_HEX    = 4'b0100,
    MODE_DROP   = 4'b1000
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [3:0]  digits_q, digits_d;
  logic [31:0] acc_q, acc_d;
  logic        enable_q;
  logic        accept;
  logic [7:0]  b;
  logic [4:0]  hex;
  logic [31:0] acc_shift;
  logic [3:0]  digits_dec;
  logic [20:0] v_full;

  // Decode one hex digit: bit 4 flags a valid digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, 4'(c[2:0] - 3'd1) + HexTen};
    end
    return r;
  endfunction

  assign in_if.ready  = !q_full_i;
  assign cfg_if.ready = 1'b1;
  assign accept       = in_if.valid && in_if.ready;
  assign b            = in_if.byte_in;
  assign hex          = hex_value(b);
  assign acc_shift    = {acc_q[27:0], hex[3:0]};
  assign digits_dec   = digits_q - 4'd1;
  assign v_full       = acc_shift[20:0] - PlaneBase;

  // Classify the byte and build the command
  always_comb begin
    mode_d   = mode_q;
    digits_d = digits_q;
    acc_d    = acc_q;
    push_o   = 1'b0;
    cmd_o    = '{is_pair: 1'b0, data: {12'd0, b}, status: ST_OK, last: 1'b0};
    if (accept) begin
      if (mode_q == MODE_DROP) begin
        if (b == 8'd0) begin
          mode_d = MODE_PLAIN;
        end
      end else if (b == 8'd0) begin
        push_o       = 1'b1;
        cmd_o.data   = '0;
        cmd_o.last   = 1'b1;
        cmd_o.status = (mode_q == MODE_HEX) ? ST_BADHEX : ST_OK;
        mode_d       = MODE_PLAIN;
        digits_d     = '0;
        acc_d        = '0;
      end else if (b[7]) begin
        push_o       = 1'b1;
        cmd_o.data   = '0;
        cmd_o.last   = 1'b1;
        cmd_o.status = ST_NONASCII;
        mode_d       = MODE_DROP;
        digits_d     = '0;
        acc_d        = '0;
      end else begin
        unique case (mode_q)
          MODE_PLAIN: begin
            if (b == ChBackslash && enable_q) begin
              mode_d = MODE_BSLASH;
            end else begin
              push_o = 1'b1;
            end
          end
          MODE_BSLASH: begin
            if (b == ChLowerU || b == ChUpperU) begin
              mode_d   = MODE_HEX;
              digits_d = (b == ChLowerU) ? ShortDigits : LongDigits;
              acc_d    = '0;
            end else begin
              mode_d = MODE_PLAIN;
              push_o = 1'b1;
            end
          end
          MODE_HEX: begin
            if (!hex[4]) begin
              push_o       = 1'b1;
              cmd_o.data   = '0;
              cmd_o.last   = 1'b1;
              cmd_o.status = ST_BADHEX;
              mode_d       = MODE_DROP;
              digits_d     = '0;
              acc_d        = '0;
            end else if (digits_dec != 4'd0) begin
              acc_d    = acc_shift;
              digits_d = digits_dec;
            end else begin
              digits_d = '0;
              acc_d    = '0;
              push_o   = 1'b1;
              if (acc_shift > MaxPoint) begin
                mode_d       = MODE_DROP;
                cmd_o.data   = '0;
                cmd_o.last   = 1'b1;
                cmd_o.status = ST_TOOBIG;
              end else if (acc_shift[31:16] == 16'd0) begin
                mode_d     = MODE_PLAIN;
                cmd_o.data = {4'd0, acc_shift[15:0]};
              end else begin
                mode_d        = MODE_PLAIN;
                cmd_o.is_pair = 1'b1;
                cmd_o.data    = v_full[19:0];
              end
            end
          end
          default: begin
            mode_d = MODE_PLAIN;
          end
        endcase
      end
    end
  end

  // Hold parse state and the enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PLAIN;
      digits_q <= '0;
      acc_q    <= '0;
      enable_q <= 1'b1;
    end else begin
      mode_q   <= mode_d;
      digits_q <= digits_d;
      acc_q    <= acc_d;
      if (cfg_if.valid) begin
        enable_q <= cfg_if.escape_enable;
      end
    end
  end

endmodule

// ===== hdl/euu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euu_queue
// Small command FIFO between the parser and the emitter.
// ----------------------------------------------------------------------------
module euu_queue #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  euu_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output euu_pkg::cmd_t head_o
);
  import euu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CntW'(Depth);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= bump(wr_q);
      end
      if (do_pop) begin
        rd_q <= bump(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/euu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euu_back
// Emitter: turns queued commands into output beats, splitting surrogates.
// ----------------------------------------------------------------------------
module euu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  euu_pkg::cmd_t head_i,
  output logic          pop_o,
  euu_unit_if.source    out_if
);
  import euu_pkg::*;

  logic        out_valid_q;
  logic [15:0] unit_q;
  status_e     status_q;
  logic        last_q;
  logic        trail_pend_q;
  logic [9:0]  trail_q;
  logic        can_load;

  assign can_load = !out_valid_q || out_if.ready;
  assign pop_o    = can_load && !trail_pend_q && head_valid_i;

  assign out_if.valid     = out_valid_q;
  assign out_if.code_unit = unit_q;
  assign out_if.status    = status_q;
  assign out_if.last      = last_q;

  // Control: valid and pending trail unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      trail_pend_q <= 1'b0;
    end else if (can_load) begin
      if (trail_pend_q) begin
        out_valid_q  <= 1'b1;
        trail_pend_q <= 1'b0;
      end else begin
        out_valid_q  <= head_valid_i;
        trail_pend_q <= head_valid_i && head_i.is_pair;
      end
    end
  end

  // Payload: load the trail unit, the lead unit or a single unit
  always_ff @(posedge clk_i) begin
    if (can_load) begin
      if (trail_pend_q) begin
        unit_q   <= {TrailPrefix, trail_q};
        status_q <= ST_OK;
        last_q   <= 1'b0;
      end else if (head_valid_i) begin
        unit_q   <= head_i.is_pair ? {LeadPrefix, head_i.data[19:10]} : head_i.data[15:0];
        status_q <= head_i.status;
        last_q   <= head_i.last;
        trail_q  <= head_i.data[9:0];
      end
    end
  end

endmodule

// ===== hdl/escape_unicode_to_utf16_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_unicode_to_utf16_top
// Decodes \uXXXX and \UXXXXXXXX escapes in a byte string to UTF-16 units.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while the queue is not full. The
// parser classifies each byte in the cycle it is accepted and writes at most
// one command into a QueueDepth-entry FIFO; the emitter drains that FIFO into
// a registered output, so a unit passes through the FIFO entry and then the
// output register. A code point above 0xFFFF leaves as two beats, lead unit
// then trail unit, which the queue absorbs since such an escape spans at
// least ten input bytes. Input ready drops only while the queue is full under
// output back-pressure. The configuration channel is always ready.
module escape_unicode_to_utf16_top #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  euu_byte_if.sink   in_if,
  euu_unit_if.source out_if,
  euu_cfg_if.sink    cfg_if
);
  import euu_pkg::*;

  logic q_full, q_valid, push, pop;
  cmd_t cmd, head;

  euu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .cfg_if   (cfg_if),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  euu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .head_o  (head)
  );

  euu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_if       (out_if)
  );

endmodule

// ===== hdl/euu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euu_checker
// Port-level checks on the decoder output stream.
// ----------------------------------------------------------------------------
module euu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_unit_i,
  input logic [1:0]  out_status_i,
  input logic        out_last_i
);
  import euu_pkg::*;

  // Hold a stalled output beat
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_unit_i)
      && $stable(out_status_i) && $stable(out_last_i))
    else $error("output beat changed while stalled");

  // An error beat always ends the string
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> out_last_i)
    else $error("error beat without last");

  // Terminator and error beats carry a zero unit
  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_unit_i == 16'd0)
    else $error("last beat with non-zero unit");

  // Reset empties the output
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid straight after reset");

endmodule

bind escape_unicode_to_utf16_top euu_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_unit_i   (out_if.code_unit),
  .out_status_i (out_if.status),
  .out_last_i   (out_if.last)
);
